@@ rtl/integer_to_radix_digits_assert.svh @@
// Assertion macros for the radix conversion block
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// property checked at every clock edge outside reset
`define ITRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define ITRD_ASSERT_NEXT(lbl, trig, cons, msg) \
  `ITRD_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

@@ rtl/itrd_pkg.sv @@
// Shared constants, types and control struct for the radix conversion block
package itrd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = RADIX_W;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int BIT_W      = $clog2(VALUE_BITS);
  localparam int LVL        = $clog2(MAX_DIGITS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

endpackage

@@ rtl/itrd_digit_chain.sv @@
// Radix digit chain: doubles and adds one input bit per cycle while ctrl.shift is set, with carry lookahead
`include "integer_to_radix_digits_assert.svh"

module itrd_digit_chain
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  chain_ctrl_t        ctrl,
  input  logic               bit_in,
  input  logic [RADIX_W-1:0] base,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [DIGIT_W-1:0] rd_digit,
  output logic [CNT_W-1:0]   count
);

  logic [DIGIT_W-1:0]    digits      [MAX_DIGITS];
  logic [DIGIT_W-1:0]    digits_next [MAX_DIGITS];
  logic [DIGIT_W:0]      sum         [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] gen;
  logic [MAX_DIGITS-1:0] prop;
  logic [MAX_DIGITS-1:0] gl [LVL+1];
  logic [MAX_DIGITS-1:0] pl [LVL+1];
  logic [MAX_DIGITS-1:0] cin;
  logic [DIGIT_W:0]      base_x;
  logic                  top_carry;
  logic [CNT_W-1:0]      count_next;

  assign base_x = {1'b0, base};

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      gen[i]  = {digits[i], 1'b0} >= base_x;
      prop[i] = {digits[i], 1'b1} == base_x;
    end
  end

  // parallel prefix over generate and propagate
  always_comb begin
    gl[0] = gen;
    pl[0] = prop;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (i >= (1 << l)) begin
          gl[l+1][i] = gl[l][i] | (pl[l][i] & gl[l][i - (1 << l)]);
          pl[l+1][i] = pl[l][i] & pl[l][i - (1 << l)];
        end else begin
          gl[l+1][i] = gl[l][i];
          pl[l+1][i] = pl[l][i];
        end
      end
    end
  end

  always_comb begin
    cin[0] = bit_in;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      cin[i] = gl[LVL][i-1] | (pl[LVL][i-1] & bit_in);
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      sum[i] = {digits[i], cin[i]};
      if (sum[i] >= base_x) begin
        digits_next[i] = DIGIT_W'(sum[i] - base_x);
      end else begin
        digits_next[i] = sum[i][DIGIT_W-1:0];
      end
    end
  end

  always_comb begin
    top_carry  = 1'b0;
    if (count < CNT_W'(MAX_DIGITS)) begin
      top_carry = cin[count[IDX_W-1:0]];
    end
    count_next = count + CNT_W'(top_carry);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (ctrl.shift) begin
      count <= count_next;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= digits_next[i];
      end
    end
  end

  assign rd_digit = digits[rd_idx];

  `ITRD_ASSERT(a_count_bound, count <= CNT_W'(MAX_DIGITS), "digit count beyond chain length")
  `ITRD_ASSERT_NEXT(a_clear_count, ctrl.clear, count == '0, "digit count not cleared")
  `ITRD_ASSERT_NEXT(a_count_step, ctrl.shift && !ctrl.clear,
                    (count == $past(count)) || (count == $past(count) + 1),
                    "digit count moved by more than one")

endmodule

@@ rtl/itrd_sequencer.sv @@
// Conversion sequencer and output register for the radix conversion block
`include "integer_to_radix_digits_assert.svh"

module itrd_sequencer
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               negative,
  input  logic [CNT_W-1:0]   count,
  input  logic [DIGIT_W-1:0] rd_digit,
  input  logic               out_ready,
  output chain_ctrl_t        ctrl,
  output logic [IDX_W-1:0]   rd_idx,
  output logic               idle,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [BIT_W-1:0]  bit_cnt;
  logic [BIT_W-1:0]  bit_cnt_next;
  logic [IDX_W-1:0]  idx_next;
  logic              slot_free;
  logic              load;
  logic [CHAR_W-1:0] load_char;
  logic              load_last;

  assign slot_free = !out_valid || out_ready;
  assign idle      = (state == S_IDLE);
  assign ctrl      = '{clear: start, shift: (state == S_CONV)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
      rd_idx  <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
      rd_idx  <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    idx_next     = rd_idx;
    load         = 1'b0;
    load_char    = CHAR_ZERO;
    load_last    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          bit_cnt_next = '0;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        bit_cnt_next = bit_cnt + BIT_W'(1);
        if (bit_cnt == BIT_W'(VALUE_BITS - 1)) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          if (count == '0) begin
            load       = 1'b1;
            load_char  = CHAR_ZERO;
            load_last  = 1'b1;
            state_next = S_IDLE;
          end else begin
            idx_next   = IDX_W'(count - CNT_W'(1));
            load       = negative;
            load_char  = CHAR_MINUS;
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CHAR_ZERO + CHAR_W'(rd_digit);
          load_last = (rd_idx == '0);
          if (rd_idx == '0) begin
            state_next = S_IDLE;
          end else begin
            idx_next = rd_idx - IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      character <= load_char;
      last      <= load_last;
    end
  end

  `ITRD_ASSERT(a_emit_idx, state == S_EMIT |-> rd_idx < count, "digit index beyond digit count")
  `ITRD_ASSERT_NEXT(a_last_idle, load && load_last, state == S_IDLE,
                    "sequencer busy after final character")
  `ITRD_ASSERT_NEXT(a_start_conv, start, state == S_CONV && bit_cnt == '0,
                    "conversion did not begin after accept")

endmodule

@@ rtl/integer_to_radix_digits.sv @@
// Top level: signed integer to radix ASCII text, one character per transaction
//
//   channel | direction | signals                        | transaction
//   cfg     | in        | cfg_valid cfg_ready radix      | new radix
//   in      | in        | in_valid in_ready value        | one integer
//   out     | out       | out_valid out_ready character last | one character
//
// All VALUE_BITS magnitude bits of an integer pass through the digit chain, one per cycle,
// then a sign state registers '-' when negative ('0' for zero), then one digit per cycle
// while out_ready is high; the next integer is taken in the cycle after the final character
// is registered.
// Reset sets the radix to ten and empties the output register.
// A stalled output holds the sequencer; the next integer is taken once the final
// character is in the output register.
`include "integer_to_radix_digits_assert.svh"

module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [RADIX_W-1:0]           radix,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CHAR_W-1:0]            character,
  output logic                         last
);

  logic [RADIX_W-1:0]    radix_setting;
  logic [RADIX_W-1:0]    base;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] abs_value;
  logic                  negative;
  logic                  start;
  logic                  idle;
  chain_ctrl_t           ctrl;
  logic [IDX_W-1:0]      rd_idx;
  logic [DIGIT_W-1:0]    rd_digit;
  logic [CNT_W-1:0]      count;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign start     = in_valid && in_ready;
  assign base      = (radix_setting < RADIX_MIN) ? RADIX_MIN : radix_setting;
  assign abs_value = value[VALUE_BITS-1] ? (~$unsigned(value) + VALUE_BITS'(1))
                                         : $unsigned(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_setting <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_setting <= radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      negative <= 1'b0;
    end else if (start) begin
      negative <= value[VALUE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= abs_value;
    end else if (ctrl.shift) begin
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
    end
  end

  itrd_digit_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .bit_in   (mag[VALUE_BITS-1]),
    .base     (base),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .count    (count)
  );

  itrd_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .negative  (negative),
    .count     (count),
    .rd_digit  (rd_digit),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .rd_idx    (rd_idx),
    .idle      (idle),
    .out_valid (out_valid),
    .character (character),
    .last      (last)
  );

endmodule
